/* rtl/kcl_pkg.sv */
package kcl_pkg;

    localparam int CODE_DIGITS_DEF = 6;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int LOCKOUT_W = 6;
    localparam int TRIES_W   = 3;

    localparam logic [LOCKOUT_W-1:0] LOCKOUT_SECONDS_RST = 6'd30;
    localparam logic [TRIES_W-1:0]   MAX_WRONG_TRIES_RST = 3'd3;

    // register index, taken from paddr[2]
    localparam logic REG_LOCKOUT_SECONDS = 1'b0;
    localparam logic REG_MAX_WRONG_TRIES = 1'b1;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [3:0] KEY_0    = 4'd0;
    localparam logic [3:0] KEY_9    = 4'd9;
    localparam logic [3:0] KEY_A    = 4'd10;
    localparam logic [3:0] KEY_B    = 4'd11;
    localparam logic [3:0] KEY_C    = 4'd12;
    localparam logic [3:0] KEY_D    = 4'd13;
    localparam logic [3:0] KEY_STAR = 4'd14;
    localparam logic [3:0] KEY_HASH = 4'd15;

    localparam logic [4:0] ST_NONE       = 5'd0;
    localparam logic [4:0] ST_DIGIT      = 5'd1;
    localparam logic [4:0] ST_FULL       = 5'd2;
    localparam logic [4:0] ST_SHORT      = 5'd3;
    localparam logic [4:0] ST_DELETED    = 5'd4;
    localparam logic [4:0] ST_CLEARED    = 5'd5;
    localparam logic [4:0] ST_GRANTED    = 5'd6;
    localparam logic [4:0] ST_WRONG      = 5'd7;
    localparam logic [4:0] ST_LOCKOUT    = 5'd8;
    localparam logic [4:0] ST_LOCKOUT_END = 5'd9;
    localparam logic [4:0] ST_OLD_ERR    = 5'd10;
    localparam logic [4:0] ST_CHANGED    = 5'd11;
    localparam logic [4:0] ST_MISMATCH   = 5'd12;
    localparam logic [4:0] ST_COUNT_CLR  = 5'd13;
    localparam logic [4:0] ST_ADMIN_ERR  = 5'd14;
    localparam logic [4:0] ST_CLOSED     = 5'd15;
    localparam logic [4:0] ST_MENU       = 5'd16;

    typedef struct packed {
        logic       cmd;
        logic [3:0] key_code;
    } in_item_t;

    typedef struct packed {
        logic [4:0]           status;
        logic [3:0]           mode_now;
        logic [2:0]           entry_length;
        logic                 lock_open;
        logic                 alarm_on;
        logic                 locked_indicator;
        logic                 beep;
        logic [15:0]          opens_total;
        logic [LOCKOUT_W-1:0] seconds_left;
        logic [TRIES_W-1:0]   wrong_tries;
    } out_item_t;

    typedef struct packed {
        logic [LOCKOUT_W-1:0] lockout_seconds;
        logic [TRIES_W-1:0]   max_wrong_tries;
    } cfg_t;

endpackage

/* rtl/kcl_cfg.sv */
module kcl_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kcl_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [kcl_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [kcl_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output kcl_pkg::cfg_t                     cfg
);
    import kcl_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lockout_seconds <= LOCKOUT_SECONDS_RST;
            cfg_reg.max_wrong_tries <= MAX_WRONG_TRIES_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_LOCKOUT_SECONDS: cfg_reg.lockout_seconds <= pwdata[LOCKOUT_W-1:0];
                REG_MAX_WRONG_TRIES: cfg_reg.max_wrong_tries <= pwdata[TRIES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LOCKOUT_SECONDS:
                prdata = APB_DATA_W'(cfg_reg.lockout_seconds);
            REG_MAX_WRONG_TRIES:
                prdata = APB_DATA_W'(cfg_reg.max_wrong_tries);
            default: prdata = '0;
        endcase
    end

endmodule

/* rtl/kcl_core.sv */
module kcl_core #(
    parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  kcl_pkg::in_item_t  item,
    input  kcl_pkg::cfg_t      cfg,
    output kcl_pkg::out_item_t result
);
    import kcl_pkg::*;

    localparam int CW = $clog2(CODE_DIGITS + 1);
    localparam int IW = $clog2(CODE_DIGITS);

    typedef logic [CODE_DIGITS-1:0][3:0] code_t;

    typedef enum logic [3:0] {
        MODE_HOME    = 4'd0,
        MODE_ENTER   = 4'd1,
        MODE_OLD     = 4'd2,
        MODE_NEW     = 4'd3,
        MODE_CONFIRM = 4'd4,
        MODE_ADMIN   = 4'd5,
        MODE_OPEN    = 4'd6,
        MODE_VIEW    = 4'd7,
        MODE_LOCK    = 4'd8
    } mode_t;

    // digits 1..9 repeating
    function automatic code_t reset_code();
        code_t      c;
        logic [3:0] d;
        d = 4'd1;
        for (int i = 0; i < CODE_DIGITS; i++) begin
            c[i] = d;
            d = (d == 4'd9) ? 4'd1 : d + 4'd1;
        end
        return c;
    endfunction

    localparam code_t CODE_RST = reset_code();

    mode_t                mode_reg,   mode_next;
    logic [CW-1:0]        count_reg,  count_next;
    code_t                entry_reg,  entry_next;
    code_t                stored_reg, stored_next;
    code_t                cand_reg,   cand_next;
    logic [TRIES_W-1:0]   wrong_reg,  wrong_next;
    logic [LOCKOUT_W-1:0] timer_reg,  timer_next;
    logic [15:0]          opens_reg,  opens_next;

    logic [4:0]         status;
    logic               beep;
    logic               alarm;
    logic               match;
    logic [TRIES_W-1:0] wrong_sat;

    assign match     = (entry_reg == stored_reg);
    assign wrong_sat = (wrong_reg < 3'd7) ? wrong_reg + 3'd1 : wrong_reg;

    always_comb begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        entry_next  = entry_reg;
        stored_next = stored_reg;
        cand_next   = cand_reg;
        wrong_next  = wrong_reg;
        timer_next  = timer_reg;
        opens_next  = opens_reg;
        status      = ST_NONE;
        beep        = 1'b0;
        alarm       = 1'b0;

        if (item.cmd == CMD_TICK) begin
            if (mode_reg == MODE_LOCK) begin
                if (timer_reg <= 6'd1) begin
                    timer_next = '0;
                    wrong_next = '0;
                    mode_next  = MODE_HOME;
                    status     = ST_LOCKOUT_END;
                end else begin
                    timer_next = timer_reg - 6'd1;
                end
            end
        end else begin
            unique case (mode_reg)
                MODE_HOME: begin
                    unique case (item.key_code) inside
                        KEY_HASH: mode_next = MODE_ENTER;
                        KEY_A:    mode_next = MODE_OLD;
                        KEY_B:    mode_next = MODE_VIEW;
                        KEY_D:    mode_next = MODE_ADMIN;
                        default:  ;
                    endcase
                    if (mode_next != MODE_HOME) begin
                        count_next = '0;
                        status     = ST_MENU;
                    end
                end
                MODE_ENTER, MODE_OLD, MODE_NEW, MODE_CONFIRM, MODE_ADMIN: begin
                    unique case (item.key_code) inside
                        [KEY_0:KEY_9]: begin
                            if (count_reg < CW'(CODE_DIGITS)) begin
                                entry_next[count_reg[IW-1:0]] = item.key_code;
                                count_next = count_reg + 1'b1;
                                status     = ST_DIGIT;
                            end else begin
                                status = ST_FULL;
                                beep   = 1'b1;
                            end
                        end
                        KEY_C: begin
                            if (count_reg != '0) begin
                                count_next = count_reg - 1'b1;
                                status     = ST_DELETED;
                            end
                        end
                        KEY_STAR: begin
                            count_next = '0;
                            status     = ST_CLEARED;
                        end
                        KEY_HASH: begin
                            beep = 1'b1;
                            if (count_reg == CW'(CODE_DIGITS)) begin
                                count_next = '0;
                                unique case (mode_reg)
                                    MODE_ENTER: begin
                                        if (match) begin
                                            wrong_next = '0;
                                            opens_next = opens_reg + 16'd1;
                                            mode_next  = MODE_OPEN;
                                            beep       = 1'b0;
                                            status     = ST_GRANTED;
                                        end else begin
                                            wrong_next = wrong_sat;
                                            alarm      = 1'b1;
                                            if (wrong_sat >= cfg.max_wrong_tries) begin
                                                mode_next  = MODE_LOCK;
                                                timer_next = cfg.lockout_seconds;
                                                status     = ST_LOCKOUT;
                                            end else begin
                                                mode_next = MODE_HOME;
                                                status    = ST_WRONG;
                                            end
                                        end
                                    end
                                    MODE_OLD: begin
                                        if (match) begin
                                            mode_next = MODE_NEW;
                                            beep      = 1'b0;
                                            status    = ST_MENU;
                                        end else begin
                                            mode_next = MODE_HOME;
                                            status    = ST_OLD_ERR;
                                        end
                                    end
                                    MODE_NEW: begin
                                        cand_next = entry_reg;
                                        mode_next = MODE_CONFIRM;
                                        beep      = 1'b0;
                                        status    = ST_MENU;
                                    end
                                    MODE_CONFIRM: begin
                                        if (entry_reg == cand_reg) begin
                                            stored_next = cand_reg;
                                            wrong_next  = '0;
                                            status      = ST_CHANGED;
                                        end else begin
                                            status = ST_MISMATCH;
                                        end
                                        mode_next = MODE_HOME;
                                    end
                                    default: begin
                                        if (match) begin
                                            opens_next = '0;
                                            status     = ST_COUNT_CLR;
                                        end else begin
                                            status = ST_ADMIN_ERR;
                                        end
                                        mode_next = MODE_HOME;
                                    end
                                endcase
                            end else begin
                                status = ST_SHORT;
                            end
                        end
                        default: ;
                    endcase
                end
                MODE_OPEN: begin
                    if (item.key_code == KEY_STAR) begin
                        mode_next = MODE_HOME;
                        status    = ST_CLOSED;
                        beep      = 1'b1;
                    end
                end
                MODE_VIEW: begin
                    if (item.key_code == KEY_STAR) begin
                        mode_next = MODE_HOME;
                        status    = ST_MENU;
                    end
                end
                default: ;
            endcase
        end

        if (mode_next == MODE_LOCK) begin
            alarm = 1'b1;
        end
    end

    always_comb begin
        result.status           = status;
        result.mode_now         = mode_next;
        result.entry_length     = 3'(count_next);
        result.lock_open        = (mode_next == MODE_OPEN);
        result.alarm_on         = alarm;
        result.locked_indicator = (mode_next != MODE_OPEN);
        result.beep             = beep;
        result.opens_total      = opens_next;
        result.seconds_left     = timer_next;
        result.wrong_tries      = wrong_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_HOME;
            count_reg  <= '0;
            stored_reg <= CODE_RST;
            wrong_reg  <= '0;
            timer_reg  <= '0;
            opens_reg  <= '0;
        end else if (step_en) begin
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            stored_reg <= stored_next;
            wrong_reg  <= wrong_next;
            timer_reg  <= timer_next;
            opens_reg  <= opens_next;
        end
    end

    // entry and candidate digits are only compared after being written
    always_ff @(posedge aclk) begin
        if (step_en) begin
            entry_reg <= entry_next;
            cand_reg  <= cand_next;
        end
    end

endmodule

/* rtl/keypad_code_lock_controller_top.sv */
// keypad code lock controller
//
// s_ channel: one item per key press (cmd 0, key_code) or one-second tick
// (cmd 1). m_ channel: exactly one result item per input item, in order.
// valid/ready on both sides; an item moves on valid && ready.
// apb port: lockout_seconds at 0x0, max_wrong_tries at 0x4, write at the
// access phase, pready tied high, reads return the register value.
//
// an accepted item goes into the input register, then through the decision
// logic into the result register, which drives m_.
// throughput: one item per cycle while m_ready is high; the input register refills in the same
// cycle that it hands its item on, so only the result register sets it.
// when m_ready is low the result register holds, the input register keeps
// one more item, and s_ready drops until the result is taken.
// reset (aresetn low, synchronous): both registers empty, mode home, counters
// and timer zero, stored code 1 2 3 4 5 6, config back to 30 and 3.
module keypad_code_lock_controller_top #(
    parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  kcl_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output kcl_pkg::out_item_t             m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kcl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [kcl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [kcl_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import kcl_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      advance;
    cfg_t      cfg;
    out_item_t result;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    kcl_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kcl_core #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

endmodule

/* rtl/kcl_checker.sv */
module kcl_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input kcl_pkg::out_item_t m_data
);
    import kcl_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    a_lock_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.lock_open != m_data.locked_indicator))
        else $error("lock_open and locked_indicator disagree");

    a_granted_open: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_GRANTED |-> m_data.lock_open && !m_data.beep)
        else $error("granted item without open lock");

    a_lockout_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_LOCKOUT |-> m_data.alarm_on && m_data.beep
            && !m_data.lock_open)
        else $error("lockout item without alarm");

    a_lockout_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_LOCKOUT_END |->
            m_data.wrong_tries == '0 && m_data.seconds_left == '0 && !m_data.alarm_on)
        else $error("lockout end left counters set");

endmodule

bind keypad_code_lock_controller_top kcl_checker u_kcl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* dv/tb_keypad_code_lock_controller_top.sv */
`timescale 1ns / 100ps

module tb_keypad_code_lock_controller_top;

    import kcl_pkg::*;

    localparam int NDIG = CODE_DIGITS_DEF;

    localparam logic [3:0] MODE_HOME    = 4'd0;
    localparam logic [3:0] MODE_ENTER   = 4'd1;
    localparam logic [3:0] MODE_OLD     = 4'd2;
    localparam logic [3:0] MODE_NEW     = 4'd3;
    localparam logic [3:0] MODE_CONFIRM = 4'd4;
    localparam logic [3:0] MODE_ADMIN   = 4'd5;
    localparam logic [3:0] MODE_OPEN    = 4'd6;
    localparam logic [3:0] MODE_VIEW    = 4'd7;
    localparam logic [3:0] MODE_LOCKOUT = 4'd8;

    typedef logic [NDIG-1:0][3:0] code_t;

    typedef struct packed {
        logic      typed;
        in_item_t  item;
        out_item_t want;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    keypad_code_lock_controller_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // lock state as the predictor sees it
    logic [3:0]           lk_mode;
    code_t                lk_entry;
    logic [2:0]           lk_len;
    code_t                lk_code;
    code_t                lk_cand;
    logic [2:0]           lk_wrong;
    logic [LOCKOUT_W-1:0] lk_timer;
    logic [15:0]          lk_opens;
    logic [LOCKOUT_W-1:0] lk_lock_secs;
    logic [TRIES_W-1:0]   lk_max_tries;

    out_item_t   lock_exp[$];
    in_item_t    pend[$];
    int unsigned live_items = 0;
    int unsigned mismatches = 0;
    bit          no_idle = 1'b0;

    function automatic out_item_t lock_step(in_item_t it);
        out_item_t  r;
        logic [4:0] st;
        logic [3:0] nxt;
        bit         beep;
        bit         alarm;
        bit         hit;
        st = ST_NONE;
        beep = 1'b0;
        alarm = 1'b0;
        if (it.cmd == CMD_TICK) begin
            if (lk_mode == MODE_LOCKOUT) begin
                if (lk_timer <= 1) begin
                    lk_timer = '0;
                    lk_wrong = '0;
                    lk_mode = MODE_HOME;
                    st = ST_LOCKOUT_END;
                end else begin
                    lk_timer = lk_timer - 1'b1;
                end
            end
        end else if (lk_mode == MODE_HOME) begin
            case (it.key_code)
                KEY_HASH: nxt = MODE_ENTER;
                KEY_A:    nxt = MODE_OLD;
                KEY_B:    nxt = MODE_VIEW;
                KEY_D:    nxt = MODE_ADMIN;
                default:  nxt = MODE_HOME;
            endcase
            if (nxt != MODE_HOME) begin
                lk_mode = nxt;
                lk_len = '0;
                st = ST_MENU;
            end
        end else if (lk_mode >= MODE_ENTER && lk_mode <= MODE_ADMIN) begin
            if (it.key_code <= KEY_9) begin
                if (lk_len < NDIG) begin
                    lk_entry[lk_len] = it.key_code;
                    lk_len = lk_len + 1'b1;
                    st = ST_DIGIT;
                end else begin
                    st = ST_FULL;
                    beep = 1'b1;
                end
            end else if (it.key_code == KEY_C) begin
                if (lk_len > 0) begin
                    lk_len = lk_len - 1'b1;
                    st = ST_DELETED;
                end
            end else if (it.key_code == KEY_STAR) begin
                lk_len = '0;
                st = ST_CLEARED;
            end else if (it.key_code == KEY_HASH) begin
                beep = 1'b1;
                if (lk_len != NDIG) begin
                    st = ST_SHORT;
                end else begin
                    hit = (lk_entry == lk_code);
                    case (lk_mode)
                        MODE_ENTER: begin
                            if (hit) begin
                                lk_wrong = '0;
                                lk_opens = lk_opens + 1'b1;
                                lk_mode = MODE_OPEN;
                                beep = 1'b0;
                                st = ST_GRANTED;
                            end else begin
                                if (lk_wrong < 7) lk_wrong = lk_wrong + 1'b1;
                                alarm = 1'b1;
                                if (lk_wrong >= lk_max_tries) begin
                                    lk_mode = MODE_LOCKOUT;
                                    lk_timer = lk_lock_secs;
                                    st = ST_LOCKOUT;
                                end else begin
                                    lk_mode = MODE_HOME;
                                    st = ST_WRONG;
                                end
                            end
                        end
                        MODE_OLD: begin
                            if (hit) begin
                                lk_mode = MODE_NEW;
                                beep = 1'b0;
                                st = ST_MENU;
                            end else begin
                                lk_mode = MODE_HOME;
                                st = ST_OLD_ERR;
                            end
                        end
                        MODE_NEW: begin
                            lk_cand = lk_entry;
                            lk_mode = MODE_CONFIRM;
                            beep = 1'b0;
                            st = ST_MENU;
                        end
                        MODE_CONFIRM: begin
                            if (lk_entry == lk_cand) begin
                                lk_code = lk_cand;
                                lk_wrong = '0;
                                st = ST_CHANGED;
                            end else begin
                                st = ST_MISMATCH;
                            end
                            lk_mode = MODE_HOME;
                        end
                        default: begin
                            if (hit) begin
                                lk_opens = '0;
                                st = ST_COUNT_CLR;
                            end else begin
                                st = ST_ADMIN_ERR;
                            end
                            lk_mode = MODE_HOME;
                        end
                    endcase
                    lk_len = '0;
                end
            end
        end else if (lk_mode == MODE_OPEN) begin
            if (it.key_code == KEY_STAR) begin
                lk_mode = MODE_HOME;
                st = ST_CLOSED;
                beep = 1'b1;
            end
        end else if (lk_mode == MODE_VIEW) begin
            if (it.key_code == KEY_STAR) begin
                lk_mode = MODE_HOME;
                st = ST_MENU;
            end
        end
        if (lk_mode == MODE_LOCKOUT) alarm = 1'b1;
        r.status = st;
        r.mode_now = lk_mode;
        r.entry_length = lk_len;
        r.lock_open = (lk_mode == MODE_OPEN);
        r.alarm_on = alarm;
        r.locked_indicator = (lk_mode != MODE_OPEN);
        r.beep = beep;
        r.opens_total = lk_opens;
        r.seconds_left = lk_timer;
        r.wrong_tries = lk_wrong;
        return r;
    endfunction

    // result of a key straight after reset, counters all zero
    function automatic out_item_t fresh_res(logic [4:0] st, logic [3:0] md, logic bp);
        out_item_t r;
        r = '0;
        r.status = st;
        r.mode_now = md;
        r.locked_indicator = 1'b1;
        r.beep = bp;
        return r;
    endfunction

    function automatic plan_row_t plan_row(logic c, logic [3:0] k, logic typed,
                                           out_item_t want);
        plan_row_t r;
        r.typed = typed;
        r.item.cmd = c;
        r.item.key_code = k;
        r.want = want;
        return r;
    endfunction

    function automatic void add_item(logic c, logic [3:0] k);
        in_item_t it;
        it.cmd = c;
        it.key_code = k;
        pend.push_back(it);
    endfunction

    function automatic code_t pick_code(int unsigned pct_right);
        code_t c;
        int unsigned j;
        c = lk_code;
        if ($urandom_range(99) >= pct_right) begin
            if ($urandom_range(1)) begin
                for (int i = 0; i < NDIG; i++) c[i] = 4'($urandom_range(9));
            end else begin
                j = $urandom_range(NDIG - 1);
                c[j] = 4'((c[j] + 1 + $urandom_range(8)) % 10);
            end
        end
        return c;
    endfunction

    // digits of a code, with the odd typo, restart or early accept
    function automatic void add_code(code_t c);
        for (int i = 0; i < NDIG; i++) begin
            if ($urandom_range(99) < 6) begin
                add_item(CMD_KEY, 4'($urandom_range(9)));
                add_item(CMD_KEY, KEY_C);
            end
            if ($urandom_range(99) < 2) begin
                add_item(CMD_KEY, KEY_STAR);
                for (int j = 0; j < i; j++) add_item(CMD_KEY, c[j]);
            end
            if ($urandom_range(99) < 3) add_item(CMD_KEY, KEY_HASH);
            add_item(CMD_KEY, c[i]);
        end
        if ($urandom_range(99) < 8) add_item(CMD_KEY, 4'($urandom_range(9)));
    endfunction

    function automatic void add_noise(int unsigned lo, int unsigned hi);
        repeat ($urandom_range(lo, hi)) add_item(CMD_KEY, 4'($urandom_range(15)));
    endfunction

    function automatic void plan_sequence();
        int unsigned pick;
        int unsigned n;
        code_t       fresh;
        pick = $urandom_range(99);
        case (lk_mode)
            MODE_LOCKOUT: begin
                n = (pick < 60) ? lk_timer : $urandom_range(1, 4);
                if (n == 0) n = 1;
                repeat (n) begin
                    if ($urandom_range(9) == 0) add_item(CMD_KEY, 4'($urandom_range(15)));
                    add_item(CMD_TICK, 4'($urandom_range(15)));
                end
            end
            MODE_HOME: begin
                if (pick < 40) begin
                    add_item(CMD_KEY, KEY_HASH);
                    add_code(pick_code(70));
                    add_item(CMD_KEY, KEY_HASH);
                end else if (pick < 55) begin
                    fresh = pick_code(0);
                    add_item(CMD_KEY, KEY_A);
                    add_code(pick_code(85));
                    add_item(CMD_KEY, KEY_HASH);
                    add_code(fresh);
                    add_item(CMD_KEY, KEY_HASH);
                    add_code(($urandom_range(99) < 80) ? fresh : pick_code(0));
                    add_item(CMD_KEY, KEY_HASH);
                end else if (pick < 65) begin
                    add_item(CMD_KEY, KEY_B);
                    add_noise(0, 3);
                    add_item(CMD_KEY, KEY_STAR);
                end else if (pick < 75) begin
                    add_item(CMD_KEY, KEY_D);
                    add_code(pick_code(70));
                    add_item(CMD_KEY, KEY_HASH);
                end else begin
                    repeat ($urandom_range(1, 4))
                        add_item(1'($urandom_range(1)), 4'($urandom_range(15)));
                end
            end
            MODE_OPEN: begin
                add_noise(0, 3);
                add_item(CMD_KEY, KEY_STAR);
            end
            default: begin
                add_noise(1, 3);
                if (pick < 50) begin
                    add_code(pick_code(50));
                    add_item(CMD_KEY, KEY_HASH);
                end
            end
        endcase
    endfunction

    task automatic send(in_item_t it, logic typed, out_item_t typed_res);
        out_item_t res;
        s_data <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        res = lock_step(it);
        lock_exp.push_back(typed ? typed_res : res);
        live_items++;
        if (!no_idle && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
    endtask

    task automatic reg_write(logic idx, logic [APB_DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_LOCKOUT_SECONDS) lk_lock_secs = val[LOCKOUT_W-1:0];
        else lk_max_tries = val[TRIES_W-1:0];
    endtask

    task automatic wait_drained();
        while (lock_exp.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (lock_exp.size() == 0) begin
                $error("result item with nothing expected: %h", m_data);
                mismatches++;
            end else begin
                want = lock_exp.pop_front();
                cmp_field("status", 16'(want.status), 16'(m_data.status));
                cmp_field("mode_now", 16'(want.mode_now), 16'(m_data.mode_now));
                cmp_field("entry_length", 16'(want.entry_length),
                          16'(m_data.entry_length));
                cmp_field("lock_open", 16'(want.lock_open), 16'(m_data.lock_open));
                cmp_field("alarm_on", 16'(want.alarm_on), 16'(m_data.alarm_on));
                cmp_field("locked_indicator", 16'(want.locked_indicator),
                          16'(m_data.locked_indicator));
                cmp_field("beep", 16'(want.beep), 16'(m_data.beep));
                cmp_field("opens_total", want.opens_total, m_data.opens_total);
                cmp_field("seconds_left", 16'(want.seconds_left),
                          16'(m_data.seconds_left));
                cmp_field("wrong_tries", 16'(want.wrong_tries),
                          16'(m_data.wrong_tries));
            end
        end
    end

    // result side: random m_ready stalls and a periodic long hold-off, except while no_idle is set
    initial begin : result_side
        int unsigned rx_cycles;
        int unsigned hold;
        rx_cycles = 0;
        hold = 0;
        forever begin
            @(posedge aclk);
            rx_cycles++;
            if (hold != 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (!no_idle && rx_cycles % 2000 == 400) begin
                hold = 120;
                m_ready <= 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 20);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("keypad_code_lock_controller_top regression: fail");
        $finish;
    end

    initial begin : stimulus
        plan_row_t            plan [25];
        logic [LOCKOUT_W-1:0] secs;
        logic [TRIES_W-1:0]   tries;
        int unsigned          target;

        lk_mode = MODE_HOME;
        lk_entry = '0;
        lk_len = '0;
        for (int i = 0; i < NDIG; i++) lk_code[i] = 4'((i % 9) + 1);
        lk_cand = '0;
        lk_wrong = '0;
        lk_timer = '0;
        lk_opens = '0;
        lk_lock_secs = LOCKOUT_SECONDS_RST;
        lk_max_tries = MAX_WRONG_TRIES_RST;

        plan = '{
            plan_row(CMD_KEY,  4'd5,     1'b1, fresh_res(ST_NONE, MODE_HOME, 1'b0)),
            plan_row(CMD_TICK, KEY_0,    1'b1, fresh_res(ST_NONE, MODE_HOME, 1'b0)),
            plan_row(CMD_KEY,  KEY_HASH, 1'b1, fresh_res(ST_MENU, MODE_ENTER, 1'b0)),
            plan_row(CMD_KEY,  KEY_C,    1'b1, fresh_res(ST_NONE, MODE_ENTER, 1'b0)),
            plan_row(CMD_KEY,  KEY_0,    1'b0, '0),
            plan_row(CMD_KEY,  KEY_9,    1'b0, '0),
            plan_row(CMD_KEY,  KEY_C,    1'b0, '0),
            plan_row(CMD_KEY,  KEY_STAR, 1'b0, '0),
            plan_row(CMD_KEY,  KEY_HASH, 1'b1, fresh_res(ST_SHORT, MODE_ENTER, 1'b1)),
            plan_row(CMD_KEY,  4'd1,     1'b0, '0),
            plan_row(CMD_KEY,  4'd2,     1'b0, '0),
            plan_row(CMD_KEY,  4'd3,     1'b0, '0),
            plan_row(CMD_KEY,  4'd4,     1'b0, '0),
            plan_row(CMD_KEY,  4'd5,     1'b0, '0),
            plan_row(CMD_KEY,  4'd6,     1'b0, '0),
            plan_row(CMD_KEY,  KEY_9,    1'b0, '0),
            plan_row(CMD_KEY,  KEY_HASH, 1'b0, '0),
            plan_row(CMD_KEY,  KEY_A,    1'b0, '0),
            plan_row(CMD_KEY,  KEY_STAR, 1'b0, '0),
            plan_row(CMD_KEY,  KEY_B,    1'b0, '0),
            plan_row(CMD_KEY,  KEY_STAR, 1'b0, '0),
            plan_row(CMD_KEY,  KEY_D,    1'b0, '0),
            plan_row(CMD_KEY,  KEY_A,    1'b0, '0),
            plan_row(CMD_KEY,  KEY_STAR, 1'b0, '0),
            plan_row(CMD_TICK, KEY_HASH, 1'b0, '0)
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) send(plan[i].item, plan[i].typed, plan[i].want);
        s_valid <= 1'b0;

        for (int p = 0; p < 7; p++) begin
            wait_drained();
            case (p)
                0: begin secs = 6'd1;  tries = 3'd1; end
                1: begin secs = 6'd63; tries = 3'd7; end
                2: begin secs = 6'd1;  tries = 3'd7; end
                3: begin secs = 6'd63; tries = 3'd1; end
                6: begin secs = 6'd30; tries = 3'd3; end
                default: begin
                    secs = 6'($urandom_range(1, 63));
                    tries = 3'($urandom_range(1, 7));
                end
            endcase
            if ($urandom_range(1)) begin
                reg_write(REG_LOCKOUT_SECONDS, 32'(secs));
                reg_write(REG_MAX_WRONG_TRIES, 32'(tries));
            end else begin
                reg_write(REG_MAX_WRONG_TRIES, 32'(tries));
                reg_write(REG_LOCKOUT_SECONDS, 32'(secs));
            end
            no_idle = (p == 2);
            target = live_items + 232;
            while (live_items < target) begin
                plan_sequence();
                while (pend.size() != 0) send(pend.pop_front(), 1'b0, '0);
            end
            s_valid <= 1'b0;
            no_idle = 1'b0;
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && lock_exp.size() == 0) begin
            $display("keypad_code_lock_controller_top regression: pass");
        end else begin
            $display("keypad_code_lock_controller_top regression: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/kcl_pkg.sv
rtl/kcl_cfg.sv
rtl/kcl_core.sv
rtl/keypad_code_lock_controller_top.sv
rtl/kcl_checker.sv
dv/tb_keypad_code_lock_controller_top.sv
